[hdl/msvln_pkg.sv]
`timescale 1ns / 1ps
package msvln_pkg;

   localparam int STACK_DEPTH_DEF     = 16;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int CMD_QUEUE_DEPTH     = 4;
   localparam int RSP_QUEUE_DEPTH     = 2;

   localparam logic [31:0] A4_INCREMENT_RST = 32'd39370534;
   localparam logic [15:0] GAIN_UNITY       = 16'd32768;
   // 0.3 in Q15
   localparam logic [13:0] VOLUME_Q15       = 14'd9830;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_A4_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_GAIN  = 2'd1;

   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_TICK     = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   typedef enum logic [1:0] {
      CMD_NOTE_ON,
      CMD_NOTE_OFF,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [6:0] pitch;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               voice_active;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [6:0]   pitch;
   } cmd_type;

   // 2^((semi-9)/12) in Q30
   function automatic logic [30:0] semi_ratio(input logic [3:0] semi);
      logic [30:0] r;
      case (semi)
         4'd0:    r = 31'd638450708;
         4'd1:    r = 31'd676414963;
         4'd2:    r = 31'd716636691;
         4'd3:    r = 31'd759250125;
         4'd4:    r = 31'd804397493;
         4'd5:    r = 31'd852229451;
         4'd6:    r = 31'd902905651;
         4'd7:    r = 31'd956595214;
         4'd8:    r = 31'd1013477327;
         4'd9:    r = 31'd1073741824;
         4'd10:   r = 31'd1137589834;
         4'd11:   r = 31'd1205234447;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] pitch_octave(input logic [6:0] pitch);
      logic [3:0] oct;
      oct = '0;
      for (int k = 1; k <= 10; k++) begin
         if (pitch >= 7'(12 * k)) oct = 4'(k);
      end
      return oct;
   endfunction

   function automatic logic [3:0] pitch_semitone(input logic [6:0] pitch);
      logic [6:0] base;
      base = 7'(12 * pitch_octave(pitch));
      return 4'(pitch - base);
   endfunction

   // Odd polynomial of sin(pi/2*x) in Q30, rounded to Q15; evaluated at elaboration only.
   function automatic logic [14:0] quarter_sine(input logic [31:0] j, input int qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      x  = 64'(j) << (30 - qbits);
      x2 = (x * x) >> 30;
      p  = 64'd172272;
      p  = 64'd5026994 - ((x2 * p) >> 30);
      p  = 64'd85569306 - ((x2 * p) >> 30);
      p  = 64'd693598669 - ((x2 * p) >> 30);
      p  = 64'd1686629713 - ((x2 * p) >> 30);
      s  = (x * p) >> 30;
      v  = (s * 64'd32767 + 64'd536870912) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return v[14:0];
   endfunction

endpackage

[hdl/mono_synth_voice_last_note_top.sv]
`timescale 1ns / 1ps
// Sample tick: waits for room in the result queue; TICK_MUL1, TICK_MUL2, then TICK_OUT
// pushes the result. Note on: push, retune multiply, retune shift; a full stack first drops
// its bottom entry, moving the rest down one entry per cycle through the stack memory's
// single read port. Note off: only dequeued on an empty stack; a top match mutes on the last note,
// else retunes to the note below; a miss scans out all copies. Synchronous active-high reset
// empties both queues and the stack, zeroes phase and step, mutes, loads default A4 and gain.
module mono_synth_voice_last_note_top #(
   parameter int STACK_DEPTH     = msvln_pkg::STACK_DEPTH_DEF,
   parameter int SINE_TABLE_BITS = msvln_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  msvln_pkg::req_type                   req_data,
   output logic                                full,
   output logic                                empty,
   input  logic                                pop,
   output msvln_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [msvln_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                         csr_wdata
);

   logic [31:0]        a4_increment_ff, a4_increment_in;
   logic [15:0]        output_gain_ff, output_gain_in;
   msvln_pkg::cmd_type  cmd;
   logic               cmd_empty;
   logic               cmd_pop;
   logic               rsp_full_int;
   logic               rsp_push;
   msvln_pkg::rsp_type  rsp_item;

   assign csr_ready = 1'b1;

   always_comb begin
      a4_increment_in = a4_increment_ff;
      output_gain_in  = output_gain_ff;
      if (csr_valid) begin
         case (csr_index)
            msvln_pkg::CSR_A4_INCREMENT: a4_increment_in = csr_wdata;
            msvln_pkg::CSR_OUTPUT_GAIN:  output_gain_in  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a4_increment_ff <= msvln_pkg::A4_INCREMENT_RST;
         output_gain_ff  <= msvln_pkg::GAIN_UNITY;
      end else begin
         a4_increment_ff <= a4_increment_in;
         output_gain_ff  <= output_gain_in;
      end
   end

   msvln_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req      (req_data),
      .full     (full),
      .cmd_pop  (cmd_pop),
      .cmd      (cmd),
      .cmd_empty(cmd_empty)
   );

   msvln_back #(
      .STACK_DEPTH    (STACK_DEPTH),
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cmd_empty   (cmd_empty),
      .cmd_pop     (cmd_pop),
      .a4_increment(a4_increment_ff),
      .output_gain (output_gain_ff),
      .rsp_full    (rsp_full_int),
      .rsp_push    (rsp_push),
      .rsp         (rsp_item)
   );

   msvln_queue #(
      .WIDTH($bits(msvln_pkg::rsp_type)),
      .DEPTH(msvln_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .wdata(rsp_item),
      .full (rsp_full_int),
      .pop  (pop),
      .rdata(rsp_data),
      .empty(empty)
   );

   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full_int)
      else $error("sample pushed into a full result queue");

   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("request popped from an empty command queue");

   a_muted_is_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !rsp_item.voice_active) |-> (rsp_item.sample == 16'sd0))
      else $error("muted voice produced a nonzero sample");

   a_rsp_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> !empty)
      else $error("pushed sample not visible on the result side");

endmodule

[hdl/msvln_queue.sv]
`timescale 1ns / 1ps
module msvln_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = data_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) data_ff[wr_ptr_ff] <= wdata;
   end

endmodule

[hdl/msvln_front.sv]
`timescale 1ns / 1ps
module msvln_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msvln_pkg::req_type req,
   output logic              full,
   input  logic              cmd_pop,
   output msvln_pkg::cmd_type cmd,
   output logic              cmd_empty
);

   msvln_pkg::cmd_type cmd_new;
   logic               keep;
   logic               q_full;
   logic               q_push;

   // unused opcode is consumed and dropped here
   always_comb begin
      keep         = 1'b1;
      cmd_new.pitch = req.pitch;
      cmd_new.kind  = msvln_pkg::CMD_TICK;
      unique case (req.opcode)
         msvln_pkg::OP_NOTE_ON:  cmd_new.kind = msvln_pkg::CMD_NOTE_ON;
         msvln_pkg::OP_NOTE_OFF: cmd_new.kind = msvln_pkg::CMD_NOTE_OFF;
         msvln_pkg::OP_TICK:     cmd_new.kind = msvln_pkg::CMD_TICK;
         default:                keep = 1'b0;
      endcase
   end

   assign full   = q_full;
   assign q_push = push && !q_full && keep;

   msvln_queue #(
      .WIDTH($bits(msvln_pkg::cmd_type)),
      .DEPTH(msvln_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .wdata(cmd_new),
      .full (q_full),
      .pop  (cmd_pop),
      .rdata(cmd),
      .empty(cmd_empty)
   );

endmodule

[hdl/msvln_back.sv]
`timescale 1ns / 1ps
module msvln_back #(
   parameter int STACK_DEPTH     = msvln_pkg::STACK_DEPTH_DEF,
   parameter int SINE_TABLE_BITS = msvln_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  msvln_pkg::cmd_type  cmd,
   input  logic               cmd_empty,
   output logic               cmd_pop,
   input  logic [31:0]        a4_increment,
   input  logic [15:0]        output_gain,
   input  logic               rsp_full,
   output logic               rsp_push,
   output msvln_pkg::rsp_type  rsp
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int QB     = SINE_TABLE_BITS - 2;
   localparam int QLEN   = 1 << QB;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_TICK_MUL1 = 4'd1;
   localparam logic [3:0] ST_TICK_MUL2 = 4'd2;
   localparam logic [3:0] ST_TICK_OUT  = 4'd3;
   localparam logic [3:0] ST_PUSH      = 4'd4;
   localparam logic [3:0] ST_OFF_CHK   = 4'd5;
   localparam logic [3:0] ST_TOP_RD    = 4'd6;
   localparam logic [3:0] ST_RT_MUL    = 4'd7;
   localparam logic [3:0] ST_RT_SHIFT  = 4'd8;
   localparam logic [3:0] ST_SCAN      = 4'd9;

   typedef logic [14:0] qrom_type [0:QLEN];

   function automatic qrom_type build_qrom();
      qrom_type t;
      for (int i = 0; i <= QLEN; i++) begin
         t[i] = msvln_pkg::quarter_sine(32'(i), QB);
      end
      return t;
   endfunction

   localparam qrom_type QROM = build_qrom();

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [31:0]       phase_acc_ff, phase_acc_in;
   logic [31:0]       phase_step_ff, phase_step_in;
   logic              voice_on_ff, voice_on_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [6:0]        pitch_ff, pitch_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  scan_lim_ff, scan_lim_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic              shift_ff, shift_in;
   logic [3:0]        rt_oct_ff, rt_oct_in;
   logic [3:0]        rt_semi_ff, rt_semi_in;
   logic [62:0]       rt_prod_ff;
   logic [14:0]       sine_ff;
   logic              neg_ff;
   logic [30:0]       prod1_ff;
   logic [44:0]       prod2_ff;

   logic [6:0]        stack_mem [0:STACK_DEPTH-1];
   logic [6:0]        mem_rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [6:0]        mem_wd;
   logic [ADDR_W-1:0] mem_ra;

   logic [CNT_W-1:0]     cnt_m1;
   logic [CNT_W-1:0]     cnt_m2;
   logic [SINE_TABLE_BITS-1:0] tbl_idx;
   logic [QB:0]          tbl_j;
   logic [15:0]          gain_c;
   logic [5:0]           rt_sh;
   logic [63:0]          rt_round;
   logic [44:0]          mag_sum;
   logic [15:0]          mag;

   assign cnt_m1  = count_ff - CNT_W'(1);
   assign cnt_m2  = count_ff - CNT_W'(2);
   assign tbl_idx = phase_acc_ff[31 -: SINE_TABLE_BITS];
   // odd quarters run the table backwards, upper half is negated
   assign tbl_j   = tbl_idx[QB] ? ((QB + 1)'(QLEN) - {1'b0, tbl_idx[QB-1:0]})
                                : {1'b0, tbl_idx[QB-1:0]};
   assign gain_c  = (output_gain > msvln_pkg::GAIN_UNITY) ? msvln_pkg::GAIN_UNITY : output_gain;
   assign rt_sh   = 6'd35 - {2'b00, rt_oct_ff};
   assign rt_round = {1'b0, rt_prod_ff} + (64'd1 << (rt_sh - 6'd1));
   assign mag_sum = prod2_ff + 45'd536870912;
   assign mag     = {1'b0, mag_sum[44:30]};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      phase_acc_in  = phase_acc_ff;
      phase_step_in = phase_step_ff;
      voice_on_in   = voice_on_ff;
      rd_vld_in     = 1'b0;
      pitch_in      = pitch_ff;
      scan_idx_in   = scan_idx_ff;
      scan_lim_in   = scan_lim_ff;
      keep_in       = keep_ff;
      shift_in      = shift_ff;
      rt_oct_in     = rt_oct_ff;
      rt_semi_in    = rt_semi_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = pitch_ff;
      mem_ra        = '0;
      rsp_push      = 1'b0;
      rsp.voice_active = voice_on_ff;
      rsp.sample       = '0;
      if (voice_on_ff) begin
         rsp.sample = neg_ff ? -$signed(mag) : $signed(mag);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               pitch_in = cmd.pitch;
               unique case (cmd.kind)
                  msvln_pkg::CMD_TICK: begin
                     if (!rsp_full) begin
                        cmd_pop  = 1'b1;
                        state_in = ST_TICK_MUL1;
                     end
                  end
                  msvln_pkg::CMD_NOTE_ON: begin
                     cmd_pop = 1'b1;
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        // full stack: drop the bottom entry by shifting all down
                        scan_idx_in = CNT_W'(1);
                        scan_lim_in = CNT_W'(STACK_DEPTH);
                        keep_in     = '0;
                        shift_in    = 1'b1;
                        state_in    = ST_SCAN;
                     end else begin
                        state_in = ST_PUSH;
                     end
                  end
                  msvln_pkg::CMD_NOTE_OFF: begin
                     cmd_pop = 1'b1;
                     if (count_ff != '0) begin
                        mem_ra   = cnt_m1[ADDR_W-1:0];
                        state_in = ST_OFF_CHK;
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         ST_TICK_MUL1: state_in = ST_TICK_MUL2;
         ST_TICK_MUL2: state_in = ST_TICK_OUT;
         ST_TICK_OUT: begin
            rsp_push     = 1'b1;
            phase_acc_in = phase_acc_ff + phase_step_ff;
            state_in     = ST_IDLE;
         end
         ST_PUSH: begin
            mem_we       = 1'b1;
            mem_wa       = count_ff[ADDR_W-1:0];
            mem_wd       = pitch_ff;
            count_in     = count_ff + CNT_W'(1);
            phase_acc_in = '0;
            voice_on_in  = 1'b1;
            rt_oct_in    = msvln_pkg::pitch_octave(pitch_ff);
            rt_semi_in   = msvln_pkg::pitch_semitone(pitch_ff);
            state_in     = ST_RT_MUL;
         end
         ST_OFF_CHK: begin
            if (mem_rd_ff == pitch_ff) begin
               count_in = cnt_m1;
               if (cnt_m1 == '0) begin
                  voice_on_in = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  mem_ra   = cnt_m2[ADDR_W-1:0];
                  state_in = ST_TOP_RD;
               end
            end else begin
               scan_idx_in = '0;
               scan_lim_in = count_ff;
               keep_in     = '0;
               shift_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_TOP_RD: begin
            rt_oct_in  = msvln_pkg::pitch_octave(mem_rd_ff);
            rt_semi_in = msvln_pkg::pitch_semitone(mem_rd_ff);
            state_in   = ST_RT_MUL;
         end
         ST_RT_MUL: state_in = ST_RT_SHIFT;
         ST_RT_SHIFT: begin
            phase_step_in = 32'(rt_round >> rt_sh);
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            // read one entry per cycle, write back the survivors compacted at keep
            if (scan_idx_ff < scan_lim_ff) begin
               mem_ra      = scan_idx_ff[ADDR_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               rd_vld_in   = 1'b1;
            end
            if (rd_vld_ff && (shift_ff || (mem_rd_ff != pitch_ff))) begin
               mem_we  = 1'b1;
               mem_wa  = keep_ff[ADDR_W-1:0];
               mem_wd  = mem_rd_ff;
               keep_in = keep_ff + CNT_W'(1);
            end
            if ((scan_idx_ff >= scan_lim_ff) && !rd_vld_ff) begin
               count_in = keep_ff;
               if (shift_ff) begin
                  state_in = ST_PUSH;
               end else begin
                  if (keep_ff == '0) voice_on_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         phase_acc_ff  <= '0;
         phase_step_ff <= '0;
         voice_on_ff   <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         phase_acc_ff  <= phase_acc_in;
         phase_step_ff <= phase_step_in;
         voice_on_ff   <= voice_on_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff    <= pitch_in;
      scan_idx_ff <= scan_idx_in;
      scan_lim_ff <= scan_lim_in;
      keep_ff     <= keep_in;
      shift_ff    <= shift_in;
      rt_oct_ff   <= rt_oct_in;
      rt_semi_ff  <= rt_semi_in;
      rt_prod_ff  <= 63'(a4_increment) * 63'(msvln_pkg::semi_ratio(rt_semi_ff));
      sine_ff     <= QROM[tbl_j];
      neg_ff      <= tbl_idx[QB+1];
      prod1_ff    <= 31'(sine_ff) * 31'(gain_c);
      prod2_ff    <= 45'(prod1_ff) * 45'(msvln_pkg::VOLUME_Q15);
   end

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[mem_wa] <= mem_wd;
      mem_rd_ff <= stack_mem[mem_ra];
   end

endmodule

[test/mono_synth_voice_last_note_top_tb.sv]
`timescale 1ns / 1ps
module mono_synth_voice_last_note_top_tb;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          SETTLE_WAIT  = 150;
   localparam logic [1:0]  CSR_UNMAPPED = 2'd3;
   localparam int          TABLE_LEN    = 1 << msvln_pkg::SINE_TABLE_BITS_DEF;

   // Tracks the voice state and the samples it should produce.
   class voice_scoreboard;
      bit [31:0]  a4_step;
      bit [15:0]  gain_word;
      logic [6:0] held_pitch [msvln_pkg::STACK_DEPTH_DEF];
      int         held_total;
      bit [31:0]  phase;
      bit [31:0]  step;
      bit         sounding;
      bit [30:0]  ratio_q30 [12];
      int         sine_q15 [TABLE_LEN];
      msvln_pkg::rsp_type pending_samples [$];
      int         mismatches;

      function new();
         int qbits;
         int unsigned q;
         int unsigned j;
         int v;
         ratio_q30 = '{31'd638450708, 31'd676414963, 31'd716636691, 31'd759250125,
                       31'd804397493, 31'd852229451, 31'd902905651, 31'd956595214,
                       31'd1013477327, 31'd1073741824, 31'd1137589834, 31'd1205234447};
         qbits = msvln_pkg::SINE_TABLE_BITS_DEF - 2;
         for (int i = 0; i < TABLE_LEN; i++) begin
            q = i >> qbits;
            j = i & ((1 << qbits) - 1);
            if (q[0]) j = (1 << qbits) - j;
            v = quarter_wave(j, qbits);
            sine_q15[i] = q[1] ? -v : v;
         end
         a4_step    = msvln_pkg::A4_INCREMENT_RST;
         gain_word  = msvln_pkg::GAIN_UNITY;
         held_total = 0;
         phase      = '0;
         step       = '0;
         sounding   = 1'b0;
         mismatches = 0;
      endfunction

      // sin(pi/2*x) odd polynomial in Q30, rounded to Q15
      function int quarter_wave(int unsigned j, int qbits);
         bit [63:0] x;
         bit [63:0] x2;
         bit [63:0] p;
         bit [63:0] s;
         bit [63:0] v;
         x  = 64'(j) << (30 - qbits);
         x2 = (x * x) >> 30;
         p  = 64'd172272;
         p  = 64'd5026994 - ((x2 * p) >> 30);
         p  = 64'd85569306 - ((x2 * p) >> 30);
         p  = 64'd693598669 - ((x2 * p) >> 30);
         p  = 64'd1686629713 - ((x2 * p) >> 30);
         s  = (x * p) >> 30;
         v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) v = 64'd32767;
         return int'(v);
      endfunction

      function void retune(logic [6:0] pitch);
         int unsigned shift;
         bit [63:0] prod;
         shift = 35 - (pitch / 12);
         prod  = 64'(a4_step) * 64'(ratio_q30[pitch % 12]);
         prod  = (prod + (64'd1 << (shift - 1))) >> shift;
         step  = prod[31:0];
      endfunction

      function void load_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            msvln_pkg::CSR_A4_INCREMENT: a4_step = value;
            msvln_pkg::CSR_OUTPUT_GAIN:  gain_word = value[15:0];
            default: ;
         endcase
      endfunction

      function void note_request(msvln_pkg::req_type r);
         int k;
         int s;
         int val;
         bit [31:0] g;
         bit [63:0] mag;
         msvln_pkg::rsp_type want;
         case (r.opcode)
            msvln_pkg::OP_NOTE_ON: begin
               // full stack drops the oldest held note
               if (held_total >= msvln_pkg::STACK_DEPTH_DEF) begin
                  for (int i = 1; i < msvln_pkg::STACK_DEPTH_DEF; i++)
                     held_pitch[i-1] = held_pitch[i];
                  held_total = msvln_pkg::STACK_DEPTH_DEF - 1;
               end
               held_pitch[held_total] = r.pitch;
               held_total++;
               retune(r.pitch);
               phase    = '0;
               sounding = 1'b1;
            end
            msvln_pkg::OP_NOTE_OFF: begin
               if (held_total != 0) begin
                  if (held_pitch[held_total-1] == r.pitch) begin
                     held_total--;
                     if (held_total > 0) retune(held_pitch[held_total-1]);
                  end else begin
                     k = 0;
                     for (int i = 0; i < held_total; i++) begin
                        if (held_pitch[i] != r.pitch) begin
                           held_pitch[k] = held_pitch[i];
                           k++;
                        end
                     end
                     held_total = k;
                  end
                  if (held_total == 0) sounding = 1'b0;
               end
            end
            msvln_pkg::OP_TICK: begin
               s   = sine_q15[phase >> (32 - msvln_pkg::SINE_TABLE_BITS_DEF)];
               g   = (gain_word > msvln_pkg::GAIN_UNITY) ? 32'(msvln_pkg::GAIN_UNITY)
                                                         : 32'(gain_word);
               val = 0;
               if (sounding) begin
                  mag = 64'(s < 0 ? -s : s);
                  mag = (mag * 64'(g) * 64'(msvln_pkg::VOLUME_Q15) + (64'd1 << 29)) >> 30;
                  val = (s < 0) ? -int'(mag) : int'(mag);
               end
               want.sample       = val[15:0];
               want.voice_active = sounding;
               pending_samples.insert(pending_samples.size(), want);
               phase = phase + step;
            end
            default: ;
         endcase
      endfunction

      function void check_result(msvln_pkg::rsp_type got);
         msvln_pkg::rsp_type want;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: unexpected sample %0d active %0b",
                        got.sample, got.voice_active);
            return;
         end
         want = pending_samples.pop_front();
         if (got.sample !== want.sample || got.voice_active !== want.voice_active) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: sample exp %0d got %0d, active exp %0b got %0b",
                        want.sample, got.sample, want.voice_active, got.voice_active);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   push;
   msvln_pkg::req_type     req_data;
   logic                   full;
   logic                   empty;
   logic                   pop;
   msvln_pkg::rsp_type     rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [msvln_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;

   voice_scoreboard sb = new();
   bit  steady_flow = 1'b0;
   int  pop_wait = 0;
   int  cycle_count = 0;

   mono_synth_voice_last_note_top dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: takes samples, stalling at random between samples unless steady_flow is set.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_wait = 0;
      end else if (pop && !empty) begin
         sb.check_result(rsp_data);
         pop_wait = steady_flow ? 0 : $urandom_range(0, 5);
         pop <= (pop_wait == 0);
      end else if (!pop) begin
         if (pop_wait > 0) pop_wait--;
         pop <= (pop_wait == 0);
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [6:0] pitch);
      int gap;
      msvln_pkg::req_type r;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.opcode = op;
      r.pitch  = pitch;
      req_data <= r;
      push     <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_request(r);
   endtask

   // Caller lowers csr_valid after its last write.
   task automatic set_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.load_register(idx, value);
   endtask

   // Queued notes make no result, so allow time for them to finish too.
   task automatic wait_for_silence();
      push <= 1'b0;
      while (sb.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic random_requests(input int count, input int on_pct);
      int roll;
      logic [6:0] pitch;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < on_pct) begin
            // narrow pool half the time so duplicates pile up
            pitch = $urandom_range(0, 1) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(58, 65));
            send_request(msvln_pkg::OP_NOTE_ON, pitch);
         end else if (roll < on_pct + 20) begin
            pitch = 7'($urandom_range(0, 127));
            if (sb.held_total > 0 && roll % 5 != 0) begin
               if ($urandom_range(0, 1))
                  pitch = sb.held_pitch[sb.held_total-1];
               else
                  pitch = sb.held_pitch[$urandom_range(0, sb.held_total - 1)];
            end
            send_request(msvln_pkg::OP_NOTE_OFF, pitch);
         end else if (roll < 96) begin
            send_request(msvln_pkg::OP_TICK, 7'($urandom_range(0, 127)));
         end else begin
            send_request(msvln_pkg::OP_UNUSED, 7'($urandom_range(0, 127)));
         end
      end
   endtask

   initial begin
      logic [31:0] a4;
      logic [31:0] gain;
      reset     <= 1'b1;
      push      <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // muted tick, note-off on empty stack, unused opcode
      send_request(msvln_pkg::OP_TICK, 7'd0);
      send_request(msvln_pkg::OP_NOTE_OFF, 7'd5);
      send_request(msvln_pkg::OP_UNUSED, 7'd127);
      send_request(msvln_pkg::OP_NOTE_ON, 7'd0);
      send_request(msvln_pkg::OP_TICK, 7'd127);
      send_request(msvln_pkg::OP_TICK, 7'd0);
      send_request(msvln_pkg::OP_NOTE_ON, 7'd127);
      send_request(msvln_pkg::OP_TICK, 7'd0);
      send_request(msvln_pkg::OP_TICK, 7'd0);
      send_request(msvln_pkg::OP_NOTE_ON, 7'd127);
      send_request(msvln_pkg::OP_NOTE_ON, 7'd60);
      send_request(msvln_pkg::OP_TICK, 7'd0);
      // inner removal of both copies
      send_request(msvln_pkg::OP_NOTE_OFF, 7'd127);
      send_request(msvln_pkg::OP_TICK, 7'd0);
      // top match, retune to the one below
      send_request(msvln_pkg::OP_NOTE_OFF, 7'd60);
      send_request(msvln_pkg::OP_TICK, 7'd0);
      send_request(msvln_pkg::OP_NOTE_OFF, 7'd0);
      send_request(msvln_pkg::OP_TICK, 7'd0);
      wait_for_silence();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin a4 = $urandom;        gain = msvln_pkg::GAIN_UNITY;     end
            1: begin a4 = '0;              gain = '0;                        end
            2: begin a4 = 32'hFFFF_FFFF;   gain = {16'($urandom), 16'hFFFF}; end
            3: begin a4 = $urandom;        gain = {16'($urandom), 16'($urandom_range(0, 32768))}; end
            4: begin a4 = msvln_pkg::A4_INCREMENT_RST; gain = 32'd32769;     end
            5: begin a4 = $urandom_range(0, 32'h0800_0000); gain = $urandom; end
            6: begin a4 = $urandom;        gain = 32'd1;                     end
            default: begin a4 = msvln_pkg::A4_INCREMENT_RST; gain = msvln_pkg::GAIN_UNITY; end
         endcase
         if (p == 5) set_csr(CSR_UNMAPPED, $urandom);
         set_csr(msvln_pkg::CSR_A4_INCREMENT, a4);
         set_csr(msvln_pkg::CSR_OUTPUT_GAIN, gain);
         csr_valid <= 1'b0;
         steady_flow = (p % 3 == 2);
         random_requests(135, (p == 1 || p == 5) ? 40 : 22);
         wait_for_silence();
      end

      if (sb.mismatches == 0 && sb.pending_samples.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
